// ===== design/ksa_pkg.sv =====
package ksa_pkg;

    // field widths
    localparam int KEY_W = 64;
    localparam int AMT_W = 32;
    localparam int SUM_W = 48;
    localparam int STS_W = 2;

    // result status codes
    localparam logic [STS_W-1:0] STS_MERGED  = 2'd0;
    localparam logic [STS_W-1:0] STS_INSERTED = 2'd1;
    localparam logic [STS_W-1:0] STS_DROPPED = 2'd2;
    localparam logic [STS_W-1:0] STS_FLUSHED = 2'd3;

    // command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // saturation limits
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic                    cmd;
        logic [KEY_W-1:0]        key;
        logic signed [AMT_W-1:0] amount;
    } in_word_t;

    typedef struct packed {
        logic [STS_W-1:0]        status;
        logic [KEY_W-1:0]        entry_key;
        logic signed [SUM_W-1:0] total;
        logic                    last;
    } out_word_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp;    // compare key, precompute saturated sum
        logic upd;    // commit saturated sum if this cell hit
        logic load;   // append the input record here
        logic shift;  // take neighbor's entry (flush drain)
    } cell_ctrl_t;

    // sign-extend an amount to sum width
    function automatic logic signed [SUM_W-1:0] amt_ext(input logic signed [AMT_W-1:0] a);
        amt_ext = {{(SUM_W-AMT_W){a[AMT_W-1]}}, a};
    endfunction

    // 48-bit add with clamp at the signed limits
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [AMT_W-1:0] b
    );
        logic [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {{(SUM_W+1-AMT_W){b[AMT_W-1]}}, b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            sat_add = s[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sat_add = s[SUM_W-1:0];
        end
    endfunction

endpackage

// ===== design/ksa_cell.sv =====
module ksa_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ksa_pkg::cell_ctrl_t              ctrl,
    input  logic                             occupied,
    input  logic [ksa_pkg::KEY_W-1:0]        in_key,
    input  logic signed [ksa_pkg::AMT_W-1:0] in_amount,
    input  logic [ksa_pkg::KEY_W-1:0]        nb_key,
    input  logic signed [ksa_pkg::SUM_W-1:0] nb_sum,
    output logic [ksa_pkg::KEY_W-1:0]        key_o,
    output logic signed [ksa_pkg::SUM_W-1:0] sum_o,
    output logic signed [ksa_pkg::SUM_W-1:0] sat_o,
    output logic                             hit_o
);
    import ksa_pkg::*;

    logic [KEY_W-1:0]        key_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sat_reg;
    logic                    hit_reg;

    // key match and speculative sum, registered ahead of the commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctrl.cmp) begin
            hit_reg <= occupied && (key_reg == in_key);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.cmp) begin
            sat_reg <= sat_add(sum_reg, in_amount);
        end
    end

    // entry storage: drain shift, append, or merge
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            key_reg <= nb_key;
            sum_reg <= nb_sum;
        end else if (ctrl.load) begin
            key_reg <= in_key;
            sum_reg <= amt_ext(in_amount);
        end else if (ctrl.upd && hit_reg) begin
            sum_reg <= sat_reg;
        end
    end

    assign key_o = key_reg;
    assign sum_o = sum_reg;
    assign sat_o = sat_reg;
    assign hit_o = hit_reg;

endmodule

// ===== design/keyed_sum_aggregator_top.sv =====
// Keyed sum aggregator: a table of up to TABLE_DEPTH (key, 48-bit sum)
// entries, kept in insertion order in a row of cells.
// Input channel s_valid/s_ready/s_word: cmd add merges amount into the
// key's sum (saturating) or appends a new entry; cmd flush drains the table.
// Result channel m_valid/m_ready/m_word: one word per add (merged, inserted
// or dropped when full, always last); a flush gives one word per entry in
// insertion order with last on the final one, or a single empty-last word.
// Each add is registered, compared in parallel in all cells (CMP state),
// then committed (UPD state) as its result word is registered. A new
// add is taken in the commit state when the output register is free.
// A flush gives max(n,1) words, as the cells shift their entries toward
// cell 0 one step per word.
// Reset (aresetn low, synchronous) empties the table and drops any word in
// flight. When the receiver stalls, the output register holds its word and
// the sequencer waits; the input side is then held off by s_ready.
module keyed_sum_aggregator_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ksa_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output ksa_pkg::out_word_t m_word
);
    import ksa_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CMP   = 2'd1;
    localparam logic [1:0] ST_UPD   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    in_word_t         in_reg;
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_word_reg, m_word_next;

    logic [KEY_W-1:0]        key_arr [TABLE_DEPTH];
    logic signed [SUM_W-1:0] sum_arr [TABLE_DEPTH];
    logic signed [SUM_W-1:0] sat_arr [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  hit_vec;

    logic             out_free;
    logic             s_fire;
    logic             any_hit;
    logic signed [SUM_W-1:0] hit_sum;
    logic             do_cmp, do_upd, do_ins, do_shift;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_UPD) && out_free);
    assign s_fire   = s_valid && s_ready;
    assign any_hit  = |hit_vec;

    // select the saturated sum of the hit cell (at most one hits)
    always_comb begin
        hit_sum = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (hit_vec[i]) begin
                hit_sum = hit_sum | sat_arr[i];
            end
        end
    end

    // row of cells, each draining into its lower neighbor
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
        cell_ctrl_t              ctrl;
        logic [KEY_W-1:0]        nb_key;
        logic signed [SUM_W-1:0] nb_sum;

        assign ctrl.cmp   = do_cmp;
        assign ctrl.upd   = do_upd;
        assign ctrl.load  = do_ins && (count_reg == IDX);
        assign ctrl.shift = do_shift;

        if (g == TABLE_DEPTH - 1) begin : g_end
            assign nb_key = '0;
            assign nb_sum = '0;
        end else begin : g_mid
            assign nb_key = key_arr[g+1];
            assign nb_sum = sum_arr[g+1];
        end

        ksa_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .occupied  (IDX < count_reg),
            .in_key    (in_reg.key),
            .in_amount (in_reg.amount),
            .nb_key    (nb_key),
            .nb_sum    (nb_sum),
            .key_o     (key_arr[g]),
            .sum_o     (sum_arr[g]),
            .sat_o     (sat_arr[g]),
            .hit_o     (hit_vec[g])
        );
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        do_cmp       = 1'b0;
        do_upd       = 1'b0;
        do_ins       = 1'b0;
        do_shift     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_word.cmd == CMD_FLUSH) ? ST_FLUSH : ST_CMP;
                end
            end
            ST_CMP: begin
                do_cmp     = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_word_next.entry_key = in_reg.key;
                    m_word_next.last      = 1'b1;
                    if (any_hit) begin
                        do_upd                = 1'b1;
                        m_word_next.status    = STS_MERGED;
                        m_word_next.total     = hit_sum;
                    end else if (count_reg < CNT_FULL) begin
                        do_ins                = 1'b1;
                        count_next            = count_reg + CNT_ONE;
                        m_word_next.status    = STS_INSERTED;
                        m_word_next.total     = amt_ext(in_reg.amount);
                    end else begin
                        m_word_next.status    = STS_DROPPED;
                        m_word_next.total     = '0;
                    end
                    if (s_fire) begin
                        state_next = (s_word.cmd == CMD_FLUSH) ? ST_FLUSH : ST_CMP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_word_next.status = STS_FLUSHED;
                    if (count_reg == '0) begin
                        m_word_next.entry_key = '0;
                        m_word_next.total     = '0;
                        m_word_next.last      = 1'b1;
                        state_next            = ST_IDLE;
                    end else begin
                        do_shift              = 1'b1;
                        m_word_next.entry_key = key_arr[0];
                        m_word_next.total     = sum_arr[0];
                        m_word_next.last      = (count_reg == CNT_ONE);
                        count_next            = count_reg - CNT_ONE;
                        if (count_reg == CNT_ONE) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_word;
        end
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // table never overfills
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("entry count above table depth");

    // stored keys are unique, so a lookup hits at most one cell
    a_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> $onehot0(hit_vec))
        else $error("more than one cell matched the key");

    // a drop is only reported with a full table
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_next && !(m_valid_reg && !m_ready) && m_word_next.status == STS_DROPPED)
            |-> (count_reg == CNT_FULL))
        else $error("record dropped while table has room");

    // every add result carries last
    a_add_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && out_free) |=> (m_valid && m_word.last))
        else $error("add result without last");

endmodule

// ===== sim/tb_keyed_sum_aggregator_top.sv =====
module tb_keyed_sum_aggregator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ksa_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_POOL = 20;
    // slowest run: ~130 words of up to 16 results each under 79% stalls,
    // plus the long hold-off; taken many times over
    localparam int LIMIT = 200_000;

    // directed stimulus row: typed-in result where it is obvious
    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t want;
    } plan_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    // table copy for prediction
    logic [KEY_W-1:0]        tab_key [TABLE_DEPTH];
    logic signed [SUM_W-1:0] tab_sum [TABLE_DEPTH];
    int                      tab_used;

    out_word_t   due_q[$];
    out_word_t   due;
    plan_row_t   plan[$];
    logic [63:0] key_pool [KEY_POOL];

    int send_idle_pct;
    int stall_pct;
    int hold_len;
    int hold_left;
    bit hold_taken;
    int err_count;
    int words_in;
    int results_out;
    int n_drop;
    int n_sat;
    int n_flush;

    keyed_sum_aggregator_top #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        err_count++;
        $display("%0t ns: %s got %h, expected %h", $time, what, got, want);
    endtask

    function automatic in_word_t mk_word(input logic cmd, input logic [KEY_W-1:0] key,
                                         input logic signed [AMT_W-1:0] amt);
        in_word_t w;
        w.cmd    = cmd;
        w.key    = key;
        w.amount = amt;
        return w;
    endfunction

    function automatic out_word_t mk_res(input logic [STS_W-1:0] st,
                                         input logic [KEY_W-1:0] key,
                                         input logic signed [SUM_W-1:0] tot,
                                         input logic last);
        out_word_t r;
        r.status    = st;
        r.entry_key = key;
        r.total     = tot;
        r.last      = last;
        return r;
    endfunction

    // group-by-key table update; queues the words this input should produce
    task automatic tally_word(input in_word_t w, input bit keep);
        int        hit;
        longint    acc;
        out_word_t r;
        hit = -1;
        if (w.cmd == CMD_FLUSH) begin
            n_flush++;
            if (tab_used == 0) begin
                r = mk_res(STS_FLUSHED, '0, '0, 1'b1);
                if (keep) due_q.push_back(r);
            end
            for (int i = 0; i < tab_used; i++) begin
                r = mk_res(STS_FLUSHED, tab_key[i], tab_sum[i], i == tab_used - 1);
                if (keep) due_q.push_back(r);
            end
            tab_used = 0;
        end else begin
            for (int i = 0; i < tab_used; i++) begin
                if (hit < 0 && tab_key[i] == w.key) hit = i;
            end
            if (hit >= 0) begin
                // merge with clamp at the 48-bit limits
                acc = longint'(tab_sum[hit]) + longint'($signed(w.amount));
                if (acc > longint'(SUM_MAX)) begin
                    acc = longint'(SUM_MAX);
                    n_sat++;
                end else if (acc < longint'(SUM_MIN)) begin
                    acc = longint'(SUM_MIN);
                    n_sat++;
                end
                tab_sum[hit] = acc[SUM_W-1:0];
                r = mk_res(STS_MERGED, w.key, tab_sum[hit], 1'b1);
            end else if (tab_used < TABLE_DEPTH) begin
                tab_key[tab_used] = w.key;
                tab_sum[tab_used] = amt_ext(w.amount);
                tab_used++;
                r = mk_res(STS_INSERTED, w.key, amt_ext(w.amount), 1'b1);
            end else begin
                n_drop++;
                r = mk_res(STS_DROPPED, w.key, '0, 1'b1);
            end
            if (keep) due_q.push_back(r);
        end
    endtask

    // offer one word, with random idle cycles ahead of it; returns at acceptance
    task automatic send_word(input in_word_t w);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!(s_valid && s_ready));
        words_in++;
    endtask

    task automatic send_checked(input in_word_t w);
        send_word(w);
        tally_word(w, 1'b1);
    endtask

    // mostly pool keys so merges and full tables happen; some raw keys
    function automatic in_word_t rand_word();
        in_word_t w;
        w.cmd = ($urandom_range(0, 11) == 0) ? CMD_FLUSH : CMD_ADD;
        if ($urandom_range(0, 19) == 0) w.key = {$urandom, $urandom};
        else w.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        case ($urandom_range(0, 9))
            0: w.amount = 32'sh7fffffff;
            1: w.amount = 32'sh80000000;
            2, 3, 4: w.amount = 32'($urandom_range(0, 2000)) - 32'd1000;
            default: w.amount = $urandom;
        endcase
        return w;
    endfunction

    // receiver: random stalls, or one long counted hold-off once requested
    always @(posedge aclk) begin
        if (hold_len > 0 && !hold_taken) begin
            m_ready    <= 1'b0;
            hold_left  <= hold_len - 1;
            hold_taken <= 1'b1;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_out++;
            if (due_q.size() == 0) begin
                flag_mismatch("unexpected word", m_word.entry_key, '0);
            end else begin
                due = due_q.pop_front();
                if (m_word.status != due.status)
                    flag_mismatch("status", 64'(m_word.status), 64'(due.status));
                if (m_word.entry_key != due.entry_key)
                    flag_mismatch("entry_key", m_word.entry_key, due.entry_key);
                if (m_word.total != due.total)
                    flag_mismatch("total", 64'(m_word.total), 64'(due.total));
                if (m_word.last != due.last)
                    flag_mismatch("last", 64'(m_word.last), 64'(due.last));
            end
        end
    end

    // watchdog
    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("timeout: %0d results still outstanding", due_q.size());
        $display("keyed_sum_aggregator_top: mismatch");
        $finish;
    end

    initial begin
        in_word_t    w;
        logic [63:0] k;
        int          len;
        logic [63:0] key_peak;
        logic [63:0] key_trough;
        logic [63:0] key_over;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_word        = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_len      = 0;
        err_count     = 0;
        words_in      = 0;
        results_out   = 0;
        n_drop        = 0;
        n_sat         = 0;
        n_flush       = 0;
        tab_used      = 0;

        // names in low-byte-first packing
        key_peak   = 64'h0000_0000_4B41_4550;  // "PEAK"
        key_trough = 64'h0000_4847_554F_5254;  // "TROUGH"
        key_over   = 64'h574F_4C46_5245_564F;  // "OVERFLOW"

        // brand-like key pool, lengths 0..8
        for (int i = 0; i < KEY_POOL; i++) begin
            len = $urandom_range(0, 8);
            k = '0;
            for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(65, 90));
            key_pool[i] = k;
        end

        // directed plan: empty flush, extremes, zero key, fill to full, drop
        plan.push_back('{mk_word(CMD_FLUSH, '0, '0), 1'b1,
                         mk_res(STS_FLUSHED, '0, '0, 1'b1)});
        plan.push_back('{mk_word(CMD_ADD, '0, '0), 1'b1,
                         mk_res(STS_INSERTED, '0, '0, 1'b1)});
        plan.push_back('{mk_word(CMD_ADD, '0, -32'sd1), 1'b1,
                         mk_res(STS_MERGED, '0, -48'sd1, 1'b1)});
        plan.push_back('{mk_word(CMD_ADD, '1, 32'sh7fffffff), 1'b1,
                         mk_res(STS_INSERTED, '1, 48'sh7fffffff, 1'b1)});
        plan.push_back('{mk_word(CMD_ADD, '1, 32'sh80000000), 1'b1,
                         mk_res(STS_MERGED, '1, -48'sd1, 1'b1)});
        plan.push_back('{mk_word(CMD_FLUSH, '1, '1), 1'b0, '0});
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            k = 64'h0000_0044_4E41_5242 | (64'(8'h41 + i) << 40);  // "BRANDx"
            plan.push_back('{mk_word(CMD_ADD, k, $urandom), 1'b0, '0});
        end
        plan.push_back('{mk_word(CMD_ADD, key_over, 32'sd99), 1'b1,
                         mk_res(STS_DROPPED, key_over, '0, 1'b1)});
        plan.push_back('{mk_word(CMD_ADD, 64'h0000_4144_4E41_5242, -32'sd7), 1'b0, '0});
        plan.push_back('{mk_word(CMD_FLUSH, '0, '0), 1'b0, '0});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        foreach (plan[i]) begin
            send_word(plan[i].word);
            if (plan[i].typed) begin
                tally_word(plan[i].word, 1'b0);
                due_q.push_back(plan[i].want);
            end else begin
                tally_word(plan[i].word, 1'b1);
            end
        end

        // large sums: push one key well past 32 bits upward, another downward
        w = mk_word(CMD_ADD, key_peak, 32'sh7fffffff);
        repeat (3) send_checked(w);
        w = mk_word(CMD_ADD, key_trough, 32'sh80000000);
        repeat (3) send_checked(w);
        send_checked(mk_word(CMD_FLUSH, '0, '0));

        // random phases: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 79 : (ph == 3) ? 13 : 0;
            stall_pct     = (ph == 2) ? 79 : (ph == 3) ? 13 : 0;
            repeat (20) send_checked(rand_word());
        end

        // back-pressure: receiver holds off while adds keep coming
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_len      = 300;
        repeat (16) begin
            w = rand_word();
            w.cmd = CMD_ADD;
            send_checked(w);
        end
        send_checked(mk_word(CMD_FLUSH, {$urandom, $urandom}, $urandom));

        s_valid <= 1'b0;
        while (due_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d words sent, %0d results checked, %0d flushes", words_in,
                 results_out, n_flush);
        $display("%0d drops on a full table, %0d clamped sums", n_drop, n_sat);
        if (err_count == 0) begin
            $display("keyed_sum_aggregator_top: match");
        end else begin
            $display("keyed_sum_aggregator_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== keyed_sum_aggregator_top.f =====
design/ksa_pkg.sv
design/ksa_cell.sv
design/keyed_sum_aggregator_top.sv
sim/tb_keyed_sum_aggregator_top.sv
